@@ hw/rtl/mxt_pkg.sv @@
// mxt_pkg: shared types and constants for the min-extract table.
// Used by mxt_min_scan and min_extract_table; no dependencies.
package mxt_pkg;

  localparam int CAP      = 16;              // table capacity
  localparam int ADDR_W   = $clog2(CAP);     // entry address width
  localparam int CNT_W    = 5;               // fill count / count_after width
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;               // read index field width

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_DELMIN  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // One entry coming back from the table during a delete-min scan.
  typedef struct packed {
    logic                     vld;
    logic                     first;
    logic [ADDR_W-1:0]        pos;
    logic signed [DATA_W-1:0] data;
  } scan_beat_t;

endpackage

@@ hw/rtl/mxt_ram.sv @@
// mxt_ram: generic synchronous RAM, one write port, two read ports.
// Read data is registered and only updates on a read enable. No dependencies.
module mxt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rea,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     reb,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rea) begin
      rdata_a <= mem[raddr_a];
    end
    if (reb) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/mxt_min_scan.sv @@
// mxt_min_scan: running signed minimum and its position over a scan.
// Depends on mxt_pkg (scan_beat_t, ADDR_W, DATA_W).
module mxt_min_scan (
  input  logic                             clk,
  input  mxt_pkg::scan_beat_t              beat,
  output logic signed [mxt_pkg::DATA_W-1:0] best_next,
  output logic [mxt_pkg::ADDR_W-1:0]        pos_next
);
  import mxt_pkg::*;

  logic signed [DATA_W-1:0] best;
  logic [ADDR_W-1:0]        best_pos;

  // Strict less-than keeps the lowest position on ties.
  always_comb begin
    if (beat.first || (beat.data < best)) begin
      best_next = beat.data;
      pos_next  = beat.pos;
    end else begin
      best_next = best;
      pos_next  = best_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.vld) begin
      best     <= best_next;
      best_pos <= pos_next;
    end
  end

endmodule

@@ hw/rtl/min_extract_table.sv @@
// min_extract_table: unsorted table of signed 32-bit entries with fill count.
// Depends on mxt_pkg, mxt_ram, mxt_min_scan.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------
//  in      | in_valid / in_stall      | opcode, value, index
//  out     | out_valid / out_stall    | status, result_value, count_after
//
// Flow: append, failed ops and short reverses go straight to S_DONE and the
// result register; read waits in S_RD first; delete-min makes one table read
// per entry through port A; reverse writes each swapped pair in two states,
// set by the single write port (one pair = two writes).
// Reset: rst clears count, FSM and output valid. Table contents are not
// cleared; entries at or above the count are never read.
// Stalls: in_stall is high while a transaction is in progress. A finished
// result waits in the output register; the next input is taken meanwhile.
module min_extract_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        opcode,
  input  logic signed [mxt_pkg::DATA_W-1:0] value,
  input  logic [mxt_pkg::IDX_W-1:0]         index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic signed [mxt_pkg::DATA_W-1:0] result_value,
  output logic [mxt_pkg::CNT_W-1:0]         count_after
);
  import mxt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD     = 6'b000010,   // waiting on read data for a read transaction
    S_SCAN   = 6'b000100,   // delete-min: one entry per cycle through port A
    S_REV_W1 = 6'b001000,   // reverse: write low slot, prefetch next pair
    S_REV_W2 = 6'b010000,   // reverse: write high slot
    S_DONE   = 6'b100000    // result ready, waiting for the output register
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  ptr, ptr_next;           // next scan address
  logic              beat_vld, beat_vld_next; // a scan read is in flight
  logic [ADDR_W-1:0] beat_pos, beat_pos_next;
  logic [ADDR_W-1:0] lo, lo_next, hi, hi_next;
  logic [DATA_W-1:0] hold, hold_next;         // low entry of the pair being swapped
  status_t           d_status, d_status_next;
  logic [DATA_W-1:0] d_value, d_value_next;

  logic              acc;
  op_t               op;
  logic [ADDR_W-1:0] n_last;

  // RAM ports
  logic              we, rea, reb;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata, rdata_a, rdata_b;

  // Scan unit
  scan_beat_t               beat;
  logic signed [DATA_W-1:0] scan_best;
  logic [ADDR_W-1:0]        scan_pos;

  logic load_out;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign op       = op_t'(opcode);
  assign n_last   = ADDR_W'(cnt - CNT_W'(1));

  assign beat.vld   = beat_vld && (state == S_SCAN);
  assign beat.first = (beat_pos == '0);
  assign beat.pos   = beat_pos;
  assign beat.data  = $signed(rdata_a);

  mxt_ram #(
    .DEPTH (CAP),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .rea     (rea),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .reb     (reb),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  mxt_min_scan u_scan (
    .clk       (clk),
    .beat      (beat),
    .best_next (scan_best),
    .pos_next  (scan_pos)
  );

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ptr_next      = ptr;
    beat_vld_next = 1'b0;
    beat_pos_next = beat_pos;
    lo_next       = lo;
    hi_next       = hi;
    hold_next     = hold;
    d_status_next = d_status;
    d_value_next  = d_value;
    we            = 1'b0;
    waddr         = lo;
    wdata         = rdata_b;
    rea           = 1'b0;
    raddr_a       = ptr[ADDR_W-1:0];
    reb           = 1'b0;
    raddr_b       = hi - ADDR_W'(1);
    load_out      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          d_status_next = ST_OK;
          d_value_next  = '0;
          state_next    = S_DONE;
          unique case (op)
            OP_APPEND: begin
              if (cnt >= CNT_W'(CAP)) begin
                d_status_next = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cnt[ADDR_W-1:0];
                wdata    = value;
                cnt_next = cnt + CNT_W'(1);
              end
            end
            OP_DELMIN: begin
              if (cnt == '0) begin
                d_status_next = ST_EMPTY;
              end else begin
                rea           = 1'b1;
                raddr_a       = '0;
                ptr_next      = CNT_W'(1);
                beat_vld_next = 1'b1;
                beat_pos_next = '0;
                state_next    = S_SCAN;
              end
            end
            OP_REVERSE: begin
              // fewer than two entries: nothing to swap
              if (cnt >= CNT_W'(2)) begin
                rea        = 1'b1;
                raddr_a    = '0;
                reb        = 1'b1;
                raddr_b    = n_last;
                lo_next    = '0;
                hi_next    = n_last;
                state_next = S_REV_W1;
              end
            end
            OP_READ: begin
              if (CNT_W'(index) >= cnt) begin
                d_status_next = ST_RANGE;
              end else begin
                rea        = 1'b1;
                raddr_a    = ADDR_W'(index);
                state_next = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        d_value_next = rdata_a;
        state_next   = S_DONE;
      end

      S_SCAN: begin
        if (ptr < cnt) begin
          rea           = 1'b1;
          raddr_a       = ptr[ADDR_W-1:0];
          ptr_next      = ptr + CNT_W'(1);
          beat_vld_next = 1'b1;
          beat_pos_next = ptr[ADDR_W-1:0];
        end
        // last entry arriving: it also fills the freed slot
        if (beat_vld && (beat_pos == n_last)) begin
          we           = 1'b1;
          waddr        = scan_pos;
          wdata        = rdata_a;
          cnt_next     = cnt - CNT_W'(1);
          d_value_next = scan_best;
          state_next   = S_DONE;
        end
      end

      S_REV_W1: begin
        we        = 1'b1;
        waddr     = lo;
        wdata     = rdata_b;
        hold_next = rdata_a;
        // prefetch next pair; addresses differ from both slots being written
        if ((lo + ADDR_W'(1)) < (hi - ADDR_W'(1))) begin
          rea     = 1'b1;
          raddr_a = lo + ADDR_W'(1);
          reb     = 1'b1;
          raddr_b = hi - ADDR_W'(1);
        end
        state_next = S_REV_W2;
      end

      S_REV_W2: begin
        we      = 1'b1;
        waddr   = hi;
        wdata   = hold;
        lo_next = lo + ADDR_W'(1);
        hi_next = hi - ADDR_W'(1);
        if ((lo + ADDR_W'(1)) < (hi - ADDR_W'(1))) begin
          state_next = S_REV_W1;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      beat_vld <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      beat_vld <= beat_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    beat_pos <= beat_pos_next;
    lo       <= lo_next;
    hi       <= hi_next;
    hold     <= hold_next;
    d_status <= d_status_next;
    d_value  <= d_value_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= d_status;
      result_value <= $signed(d_value);
      count_after  <= cnt;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(CAP))
    else $error("fill count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (we && rea) |-> (waddr != raddr_a))
    else $error("port A read collides with write to same entry");

  a_rev_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV_W1) |-> (lo < hi))
    else $error("reverse pointers crossed");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && (op == OP_APPEND) && (cnt < CNT_W'(CAP))) |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("append did not grow count");

  a_delmin_shrinks: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (state_next == S_DONE)) |=> (cnt == $past(cnt) - CNT_W'(1)))
    else $error("delete-min did not shrink count");

endmodule
